// ----- hw/rtl/fss_pkg.sv -----
`timescale 1ns / 1ps

package fss_pkg;

    localparam int unsigned CountW  = 16;
    localparam int unsigned TimeW   = 16;
    localparam int unsigned StepW   = 17;
    localparam int unsigned AccW    = 17;
    localparam int unsigned MoveW   = 32;
    localparam int unsigned KindW   = 3;
    localparam int unsigned PhaseW  = 4;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 16;

    localparam logic [AccW-1:0]  ACC_MAX  = '1;
    localparam logic [StepW-1:0] STEP_MAX = '1;

    // item kinds
    localparam logic [KindW-1:0] KIND_TICK  = 3'd0;
    localparam logic [KindW-1:0] KIND_STACK = 3'd1;
    localparam logic [KindW-1:0] KIND_PHOTO = 3'd2;
    localparam logic [KindW-1:0] KIND_MOVE  = 3'd3;
    localparam logic [KindW-1:0] KIND_STOP  = 3'd4;

    // run modes
    localparam logic [ModeW-1:0] MODE_HALTED = 2'd0;
    localparam logic [ModeW-1:0] MODE_RUN    = 2'd1;
    localparam logic [ModeW-1:0] MODE_PAUSE  = 2'd2;

    // sub-phases
    localparam logic [PhaseW-1:0] PH_PRE_START  = 4'd0;
    localparam logic [PhaseW-1:0] PH_PRE_WAIT   = 4'd1;
    localparam logic [PhaseW-1:0] PH_SHOT_START = 4'd2;
    localparam logic [PhaseW-1:0] PH_SHOT_BUSY  = 4'd3;
    localparam logic [PhaseW-1:0] PH_SHOT_PAUSE = 4'd4;
    localparam logic [PhaseW-1:0] PH_POST_START = 4'd5;
    localparam logic [PhaseW-1:0] PH_POST_WAIT  = 4'd6;
    localparam logic [PhaseW-1:0] PH_MOVE_START = 4'd7;
    localparam logic [PhaseW-1:0] PH_MOVE_BUSY  = 4'd8;
    localparam logic [PhaseW-1:0] PH_MOVE_PAUSE = 4'd9;
    localparam logic [PhaseW-1:0] PH_NEXT_STEP  = 4'd10;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_LAST_STEP    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DELAY_BEFORE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DELAY_AFTER  = 2'd2;

    typedef struct packed {
        logic [CountW-1:0] last_step;
        logic [TimeW-1:0]  delay_before;
        logic [TimeW-1:0]  delay_after;
    } cfg_t;

    typedef struct packed {
        logic [KindW-1:0]        kind;
        logic signed [MoveW-1:0] steps;
        logic [TimeW-1:0]        elapsed;
        logic                    photo_done;
        logic                    motor_idle;
    } cmd_t;

    typedef struct packed {
        logic [ModeW-1:0]        run_mode;
        logic [PhaseW-1:0]       sub_phase;
        logic [StepW-1:0]        step_counter;
        logic [AccW-1:0]         time_accum;
        logic signed [MoveW-1:0] move_steps;
    } state_t;

    typedef struct packed {
        logic                    fire_photo;
        logic                    serve_camera;
        logic                    issue_move;
        logic signed [MoveW-1:0] move_amount;
        logic                    serve_motor;
        logic                    halt_devices;
        logic                    is_idle;
        logic                    stack_done;
        logic [StepW-1:0]        step_now;
        logic [PhaseW-1:0]       phase;
        logic [ModeW-1:0]        mode;
    } res_t;

endpackage

// ----- hw/rtl/fss_if.sv -----
`timescale 1ns / 1ps

interface fss_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [fss_pkg::KindW-1:0]           kind;
    logic signed [fss_pkg::MoveW-1:0]    steps;
    logic [fss_pkg::TimeW-1:0]           elapsed;
    logic                                photo_done;
    logic                                motor_idle;

    modport source (output valid, kind, steps, elapsed, photo_done, motor_idle,
                    input ready);
    modport sink (input valid, kind, steps, elapsed, photo_done, motor_idle,
                  output ready);
endinterface

interface fss_res_if;
    logic                                valid;
    logic                                ready;
    logic                                fire_photo;
    logic                                serve_camera;
    logic                                issue_move;
    logic signed [fss_pkg::MoveW-1:0]    move_amount;
    logic                                serve_motor;
    logic                                halt_devices;
    logic                                is_idle;
    logic                                stack_done;
    logic [fss_pkg::StepW-1:0]           step_now;
    logic [fss_pkg::PhaseW-1:0]          phase;
    logic [fss_pkg::ModeW-1:0]           mode;

    modport source (output valid, fire_photo, serve_camera, issue_move, move_amount,
                    serve_motor, halt_devices, is_idle, stack_done, step_now,
                    phase, mode, input ready);
    modport sink (input valid, fire_photo, serve_camera, issue_move, move_amount,
                  serve_motor, halt_devices, is_idle, stack_done, step_now,
                  phase, mode, output ready);
endinterface

// ----- hw/rtl/focus_stack_sequencer.sv -----
`timescale 1ns / 1ps

// An input transfer passes the input register and then the result register
// before the earliest result transfer.
// Throughput: one item per cycle; the sequencer state updates as an item leaves the input register.
// A stalled result register holds the input register, which still takes one item while empty.
// Reset (rst_n low, asynchronous): mode halted, phase 0, step 0, time 0, move 0,
// all registers 0, both pipeline registers empty.
module focus_stack_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fss_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [fss_pkg::CfgW-1:0]      cfg_wdata,
    fss_cmd_if.sink                       cmd,
    fss_res_if.source                     res
);

    // configuration registers
    fss_pkg::cfg_t   cfg_reg;
    fss_pkg::cfg_t   cfg_next;

    // sequencer state
    fss_pkg::state_t state_reg;
    fss_pkg::state_t state_next;

    // input stage
    logic            item_vld;
    fss_pkg::cmd_t   item;
    logic            take;

    // result register
    logic            res_vld_reg;
    logic            res_vld_next;
    fss_pkg::res_t   res_reg;
    fss_pkg::res_t   res_calc;

    // An item moves into the result register whenever that slot is free or
    // is being emptied by a transfer in the same cycle.
    assign take = item_vld && (!res_vld_reg || res.ready);

    fss_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    fss_step u_step
    (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item),
        .nxt  (state_next),
        .res  (res_calc)
    );

    // Register writes; an index past the list is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fss_pkg::CFG_LAST_STEP:    cfg_next.last_step    = cfg_wdata;
                fss_pkg::CFG_DELAY_BEFORE: cfg_next.delay_before = cfg_wdata;
                fss_pkg::CFG_DELAY_AFTER:  cfg_next.delay_after  = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign res_vld_next = take ? 1'b1 : ((res_vld_reg && !res.ready) ? 1'b1 : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            state_reg   <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            res_vld_reg <= res_vld_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_calc;
        end
    end

    assign res.valid        = res_vld_reg;
    assign res.fire_photo   = res_reg.fire_photo;
    assign res.serve_camera = res_reg.serve_camera;
    assign res.issue_move   = res_reg.issue_move;
    assign res.move_amount  = res_reg.move_amount;
    assign res.serve_motor  = res_reg.serve_motor;
    assign res.halt_devices = res_reg.halt_devices;
    assign res.is_idle      = res_reg.is_idle;
    assign res.stack_done   = res_reg.stack_done;
    assign res.step_now     = res_reg.step_now;
    assign res.phase        = res_reg.phase;
    assign res.mode         = res_reg.mode;

endmodule

// ----- hw/rtl/fss_in_stage.sv -----
`timescale 1ns / 1ps

// Input register: holds one item until the step logic takes it.
module fss_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    fss_cmd_if.sink        cmd,
    input  logic           take,
    output logic           item_vld,
    output fss_pkg::cmd_t  item
);

    logic          vld_reg;
    logic          vld_next;
    fss_pkg::cmd_t item_reg;
    logic          load;

    assign cmd.ready = !vld_reg || take;
    assign load      = cmd.valid && cmd.ready;
    assign vld_next  = load ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.kind       <= cmd.kind;
            item_reg.steps      <= cmd.steps;
            item_reg.elapsed    <= cmd.elapsed;
            item_reg.photo_done <= cmd.photo_done;
            item_reg.motor_idle <= cmd.motor_idle;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// ----- hw/rtl/fss_step.sv -----
`timescale 1ns / 1ps

// Next-state and result logic for one item; each tick makes at most one
// phase transition, so the phase chain does not fall through.
module fss_step
(
    input  fss_pkg::cfg_t   cfg,
    input  fss_pkg::state_t cur,
    input  fss_pkg::cmd_t   item,
    output fss_pkg::state_t nxt,
    output fss_pkg::res_t   res
);

    logic [fss_pkg::AccW:0]      acc_sum;
    logic [fss_pkg::AccW-1:0]    acc_sat;
    logic [fss_pkg::StepW-1:0]   step_inc;
    logic [fss_pkg::StepW-1:0]   count_ext;
    logic                        paused;
    logic                        advance;
    logic                        fire;
    logic                        scam;
    logic                        imove;
    logic                        smot;
    logic                        halt;

    assign acc_sum   = {1'b0, cur.time_accum} + {{(fss_pkg::AccW + 1 - fss_pkg::TimeW){1'b0}},
                                                 item.elapsed};
    assign acc_sat   = acc_sum[fss_pkg::AccW] ? fss_pkg::ACC_MAX
                                              : acc_sum[fss_pkg::AccW-1:0];
    assign count_ext = {{(fss_pkg::StepW - fss_pkg::CountW){1'b0}}, cfg.last_step};
    assign step_inc  = (cur.step_counter == fss_pkg::STEP_MAX) ? cur.step_counter
                                                               : cur.step_counter + 1'b1;
    assign paused    = (cur.run_mode == fss_pkg::MODE_PAUSE);

    always_comb
    begin
        nxt     = cur;
        fire    = 1'b0;
        scam    = 1'b0;
        imove   = 1'b0;
        smot    = 1'b0;
        halt    = 1'b0;
        advance = 1'b0;

        case (item.kind)
            fss_pkg::KIND_STACK:
            begin
                nxt.step_counter = '0;
                nxt.time_accum   = '0;
                nxt.sub_phase    = fss_pkg::PH_NEXT_STEP;
                nxt.run_mode     = fss_pkg::MODE_RUN;
                nxt.move_steps   = item.steps;
            end
            fss_pkg::KIND_PHOTO:
            begin
                nxt.step_counter = '0;
                nxt.time_accum   = '0;
                nxt.sub_phase    = fss_pkg::PH_SHOT_START;
                nxt.run_mode     = fss_pkg::MODE_PAUSE;
            end
            fss_pkg::KIND_MOVE:
            begin
                nxt.step_counter = '0;
                nxt.time_accum   = '0;
                nxt.sub_phase    = fss_pkg::PH_MOVE_START;
                nxt.run_mode     = fss_pkg::MODE_PAUSE;
                nxt.move_steps   = item.steps;
            end
            fss_pkg::KIND_STOP:
            begin
                nxt.run_mode = fss_pkg::MODE_HALTED;
                halt         = 1'b1;
            end
            fss_pkg::KIND_TICK:
            begin
                nxt.time_accum = acc_sat;
                if (cur.run_mode != fss_pkg::MODE_HALTED)
                begin
                    case (cur.sub_phase)
                        // a fresh delay starts at zero, so it never ends in the same tick
                        fss_pkg::PH_PRE_START:
                        begin
                            nxt.time_accum = '0;
                            nxt.sub_phase  = fss_pkg::PH_PRE_WAIT;
                        end
                        fss_pkg::PH_PRE_WAIT:
                        begin
                            if (acc_sat > {1'b0, cfg.delay_before})
                            begin
                                nxt.sub_phase = fss_pkg::PH_SHOT_START;
                            end
                        end
                        fss_pkg::PH_SHOT_START, fss_pkg::PH_SHOT_BUSY:
                        begin
                            fire          = (cur.sub_phase == fss_pkg::PH_SHOT_START);
                            scam          = 1'b1;
                            nxt.sub_phase = fss_pkg::PH_SHOT_BUSY;
                            if (item.photo_done)
                            begin
                                nxt.sub_phase = (cur.step_counter == count_ext)
                                                ? fss_pkg::PH_NEXT_STEP
                                                : fss_pkg::PH_SHOT_PAUSE;
                            end
                        end
                        fss_pkg::PH_SHOT_PAUSE, fss_pkg::PH_POST_START:
                        begin
                            if (!(paused && cur.sub_phase == fss_pkg::PH_SHOT_PAUSE))
                            begin
                                nxt.time_accum = '0;
                                nxt.sub_phase  = fss_pkg::PH_POST_WAIT;
                            end
                        end
                        fss_pkg::PH_POST_WAIT:
                        begin
                            if (acc_sat > {1'b0, cfg.delay_after})
                            begin
                                nxt.sub_phase = fss_pkg::PH_MOVE_START;
                            end
                        end
                        fss_pkg::PH_MOVE_START, fss_pkg::PH_MOVE_BUSY:
                        begin
                            imove         = (cur.sub_phase == fss_pkg::PH_MOVE_START);
                            smot          = 1'b1;
                            nxt.sub_phase = fss_pkg::PH_MOVE_BUSY;
                            if (item.motor_idle)
                            begin
                                nxt.sub_phase = fss_pkg::PH_MOVE_PAUSE;
                            end
                        end
                        fss_pkg::PH_MOVE_PAUSE:
                        begin
                            advance = !paused;
                        end
                        fss_pkg::PH_NEXT_STEP:
                        begin
                            advance = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (advance)
                    begin
                        nxt.step_counter = step_inc;
                        nxt.sub_phase    = fss_pkg::PH_PRE_START;
                        if (step_inc > count_ext)
                        begin
                            nxt.run_mode = fss_pkg::MODE_HALTED;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.fire_photo   = fire;
        res.serve_camera = scam;
        res.issue_move   = imove;
        res.move_amount  = imove ? cur.move_steps : '0;
        res.serve_motor  = smot;
        res.halt_devices = halt;
        res.is_idle      = (nxt.run_mode == fss_pkg::MODE_HALTED) ||
                           ((nxt.run_mode == fss_pkg::MODE_PAUSE) &&
                            ((nxt.sub_phase == fss_pkg::PH_SHOT_PAUSE) ||
                             (nxt.sub_phase == fss_pkg::PH_MOVE_PAUSE)));
        res.stack_done   = (nxt.step_counter > count_ext) &&
                           (nxt.run_mode == fss_pkg::MODE_HALTED);
        res.step_now     = nxt.step_counter;
        res.phase        = nxt.sub_phase;
        res.mode         = nxt.run_mode;
    end

endmodule

// ----- hw/rtl/fss_checker.sv -----
`timescale 1ns / 1ps

module fss_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  logic                          fire_photo,
    input  logic                          issue_move,
    input  logic                          halt_devices,
    input  logic                          is_idle,
    input  logic                          stack_done,
    input  logic [fss_pkg::StepW-1:0]     step_now,
    input  logic [fss_pkg::PhaseW-1:0]    phase,
    input  logic [fss_pkg::ModeW-1:0]     mode
);

    // a stop leaves the sequencer halted
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && halt_devices |-> mode == fss_pkg::MODE_HALTED)
        else $error("halt without halted mode");

    // a photo start leaves the camera phase or its exits
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && fire_photo |->
            phase == fss_pkg::PH_SHOT_BUSY || phase == fss_pkg::PH_SHOT_PAUSE ||
            phase == fss_pkg::PH_NEXT_STEP)
        else $error("photo fired outside camera phase");

    // a move start leaves the motor phase or its pause
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && issue_move |->
            phase == fss_pkg::PH_MOVE_BUSY || phase == fss_pkg::PH_MOVE_PAUSE)
        else $error("move issued outside motor phase");

    // a finished stack is idle and has left step 0
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && stack_done |-> is_idle && step_now != '0)
        else $error("stack done while busy");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(step_now) && $stable(phase))
        else $error("stalled result changed");

endmodule

bind focus_stack_sequencer fss_checker u_fss_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .fire_photo   (res.fire_photo),
    .issue_move   (res.issue_move),
    .halt_devices (res.halt_devices),
    .is_idle      (res.is_idle),
    .stack_done   (res.stack_done),
    .step_now     (res.step_now),
    .phase        (res.phase),
    .mode         (res.mode)
);
